// File: hw/rtl/bol_pkg.sv
`timescale 1ns / 1ps

package bol_pkg;

  localparam int unsigned DefaultCapacity = 16;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_DELETE     = 2'd2,
    OP_READ       = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_POS   = 2'd3
  } status_e;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_SHR   = 2'd1,
    CMD_LOAD  = 2'd2,
    CMD_SHL   = 2'd3
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e          cmd;
    logic signed [31:0] value;
  } cell_ctl_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] value;
    logic [3:0]         position;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         count;
    logic signed [31:0] read_value;
  } rsp_t;

endpackage

// File: hw/rtl/bol_cell.sv
`timescale 1ns / 1ps

module bol_cell (
  input  logic                       clk_i,
  input  bol_pkg::cell_ctl_t         ctl_i,
  input  logic                       sel_i,
  input  logic signed [31:0]         left_i,
  input  logic signed [31:0]         right_i,
  output logic signed [31:0]         data_o,
  output logic                       hit_o
);
  import bol_pkg::*;

  logic signed [31:0] data_q, data_d;

  // The selected cell reports whether it holds the searched value.
  assign hit_o  = sel_i && (data_q == ctl_i.value);
  assign data_o = data_q;

  always_comb begin
    data_d = data_q;
    unique case (ctl_i.cmd)
      CMD_NONE: data_d = data_q;
      CMD_SHR:  data_d = left_i;
      CMD_LOAD: if (sel_i) data_d = ctl_i.value;
      CMD_SHL:  if (sel_i) data_d = right_i;
      default:  data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// File: hw/rtl/bounded_ordered_list_top.sv
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY signed 32-bit entries held in a chain of cells, head in
// cell zero. A request is taken when start is high and busy is low, and its single result
// appears on rsp_o for exactly one cycle, marked by rsp_valid_o; the receiver cannot stall
// it. Push front, push back and read give their registered result in the cycle after they
// are taken: push front moves every cell into its right neighbor at once, push back loads
// the cell at the tail, and a read selects one of the first sixteen cells. Delete walks the
// chain one cell per cycle while busy is high (busy does not rise on an empty list), and
// its result appears in the same cycle that busy falls. Entries come up undefined after
// reset; the state, count, walk index and result strobe are cleared.
module bounded_ordered_list_top #(
  parameter int unsigned CAPACITY = bol_pkg::DefaultCapacity
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  bol_pkg::req_t req_i,
  output logic          rsp_valid_o,
  output bol_pkg::rsp_t rsp_o
);
  import bol_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned RdN  = (CAPACITY < 16) ? CAPACITY : 16;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e             state_q;
  logic [CntW-1:0]    count_q;
  logic [IdxW-1:0]    k_q;
  logic               shift_q;
  logic signed [31:0] val_q;
  logic               rsp_valid_q;
  rsp_t               rsp_q;

  cell_ctl_t          ctl;
  logic [CAPACITY-1:0] sel;
  logic [CAPACITY-1:0] hit;
  logic signed [31:0] cell_data [CAPACITY];
  logic               hit_any;
  logic               accept;
  logic               full;
  logic               pos_ok;
  logic signed [31:0] rd_val;
  logic               last_cell;

  function automatic logic [4:0] cnt5(input logic [CntW-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[4:0];
  endfunction

  assign busy      = (state_q == S_SCAN);
  assign accept    = start && !busy;
  assign full      = (32'(count_q) >= 32'(CAPACITY));
  assign hit_any   = |hit;
  assign last_cell = (CntW'(k_q) == (count_q - CntW'(1)));
  assign pos_ok    = (32'(req_i.position) < 32'(count_q)) &&
                     (32'(req_i.position) < 32'(CAPACITY));

  always_comb begin
    ctl.cmd   = CMD_NONE;
    ctl.value = req_i.value;
    if (state_q == S_SCAN) begin
      ctl.value = val_q;
      if (shift_q || hit_any) ctl.cmd = CMD_SHL;
    end else if (accept && !full) begin
      if (req_i.opcode == OP_PUSH_FRONT) ctl.cmd = CMD_SHR;
      else if (req_i.opcode == OP_PUSH_BACK) ctl.cmd = CMD_LOAD;
    end
  end

  // Selection depends on state only, so a cell's hit cannot feed back into its own select.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (state_q == S_SCAN) sel[i] = (k_q == IdxW'(i));
      else                   sel[i] = (count_q == CntW'(i));
    end
  end

  always_comb begin
    rd_val = '0;
    for (int j = 0; j < RdN; j++) begin
      if (req_i.position == 4'(j)) rd_val = cell_data[j];
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0] left, right;
    if (g == 0) begin : g_head
      assign left = ctl.value;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right = cell_data[g];
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end
    bol_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .sel_i   (sel[g]),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[g]),
      .hit_o   (hit[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      k_q         <= '0;
      shift_q     <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            rsp_q.read_value <= '0;
            unique case (req_i.opcode)
              OP_PUSH_FRONT, OP_PUSH_BACK: begin
                rsp_valid_q <= 1'b1;
                if (full) begin
                  rsp_q.status <= ST_FULL;
                  rsp_q.count  <= cnt5(count_q);
                end else begin
                  count_q      <= count_q + CntW'(1);
                  rsp_q.status <= ST_OK;
                  rsp_q.count  <= cnt5(count_q + CntW'(1));
                end
              end
              OP_DELETE: begin
                if (count_q == '0) begin
                  rsp_valid_q  <= 1'b1;
                  rsp_q.status <= ST_NOT_FOUND;
                  rsp_q.count  <= cnt5(count_q);
                end else begin
                  state_q <= S_SCAN;
                  k_q     <= '0;
                  shift_q <= 1'b0;
                  val_q   <= req_i.value;
                end
              end
              default: begin
                rsp_valid_q <= 1'b1;
                rsp_q.count <= cnt5(count_q);
                if (pos_ok) begin
                  rsp_q.status     <= ST_OK;
                  rsp_q.read_value <= rd_val;
                end else begin
                  rsp_q.status <= ST_BAD_POS;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          if (hit_any) shift_q <= 1'b1;
          if (last_cell) begin
            state_q          <= S_IDLE;
            rsp_valid_q      <= 1'b1;
            rsp_q.read_value <= '0;
            if (shift_q || hit_any) begin
              count_q      <= count_q - CntW'(1);
              rsp_q.status <= ST_OK;
              rsp_q.count  <= cnt5(count_q - CntW'(1));
            end else begin
              rsp_q.status <= ST_NOT_FOUND;
              rsp_q.count  <= cnt5(count_q);
            end
          end else begin
            k_q <= k_q + IdxW'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

`ifndef SYNTHESIS
  a_no_rsp_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !rsp_valid_o)
    else $error("result strobed during a delete walk");

  a_single_cycle_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.opcode != OP_DELETE) |=> rsp_valid_o)
    else $error("one-cycle request gave no result");

  a_walk_ends_in_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> rsp_valid_o)
    else $error("delete walk ended without a result");

  a_full_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status == ST_FULL) |-> $stable(count_q))
    else $error("dropped push changed the count");
`endif

endmodule
